// ===== design/riot_ram_interval_timer_top_macros.svh =====
// ----------------------------------------------------------------------------
// RIOT timer assertion macros
// Shared concurrent assertion helpers, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef RIOT_RAM_INTERVAL_TIMER_TOP_MACROS_SVH
`define RIOT_RAM_INTERVAL_TIMER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RIT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, named for properties that compare against the previous cycle.
`define RIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rit_pkg.sv =====
// ----------------------------------------------------------------------------
// RIOT timer package
// Shared types, codes and constants of the RAM and interval timer block.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int RAM_DEPTH   = 128;   // power of two, 16..256
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int DATA_W      = 8;
    localparam int INTERVAL_W  = 11;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_READ  = 2'd1,
        ST_BAD_WRITE = 2'd2
    } t_status;

    localparam logic [7:0] ADDR_READ_MASK = 8'hF7;  // bit 3 ignored on reads
    localparam logic [7:0] ADDR_SWITCH    = 8'h82;
    localparam logic [7:0] ADDR_TIMER     = 8'h84;
    localparam logic [7:0] ADDR_FLAGS     = 8'h85;
    localparam logic [7:0] SWITCH_VALUE   = 8'h0B;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        t_status           status;
    } t_port_rsp;

    // Prescale lengths selected by write address bits [1:0].
    function automatic logic [INTERVAL_W-1:0] prescale_len(input logic [1:0] sel);
        logic [INTERVAL_W-1:0] len;
        case (sel)
            2'd0:    len = INTERVAL_W'(1);
            2'd1:    len = INTERVAL_W'(8);
            2'd2:    len = INTERVAL_W'(64);
            default: len = INTERVAL_W'(1024);
        endcase
        return len;
    endfunction

endpackage

// ===== design/rit_ram.sv =====
// ----------------------------------------------------------------------------
// RIOT timer generic RAM
// Single write port, single read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module rit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rit_timer.sv =====
// ----------------------------------------------------------------------------
// RIOT timer port logic
// Interval timer, prescaler, flags and the I/O port decode of one request.
// ----------------------------------------------------------------------------
module rit_timer
    import rit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_op,
    input  logic              i_ram_select,
    input  logic [7:0]        i_addr,
    input  logic [7:0]        i_write_data,
    output t_port_rsp         o_rsp
);

    logic [7:0]            r_tv,    n_tv;
    logic [1:0]            r_flags, n_flags;   // {bit 7, bit 6}
    logic [INTERVAL_W-1:0] r_pc,    n_pc;
    logic [INTERVAL_W-1:0] r_ai,    n_ai;
    logic [INTERVAL_W-1:0] r_pi,    n_pi;
    logic [INTERVAL_W-1:0] pc_dec;
    logic [INTERVAL_W-1:0] len;
    logic                  step;

    always_comb begin
        n_tv    = r_tv;
        n_flags = r_flags;
        n_pc    = r_pc;
        n_ai    = r_ai;
        n_pi    = r_pi;
        o_rsp   = '{rdata: '0, status: ST_OK};
        step    = 1'b0;
        pc_dec  = r_pc - INTERVAL_W'(1);
        len     = prescale_len(i_addr[1:0]);

        if (i_accept) begin
            case (i_op)
                OP_TICK: begin
                    n_pc = pc_dec;
                    step = (pc_dec == '0);
                end
                OP_READ: begin
                    if (!i_ram_select) begin
                        unique case (i_addr & ADDR_READ_MASK)
                            ADDR_SWITCH: o_rsp.rdata = SWITCH_VALUE;
                            ADDR_TIMER: begin
                                o_rsp.rdata = r_tv;
                                // leaving the one-tick interval after underflow
                                if (r_ai == INTERVAL_W'(1)) begin
                                    n_pc = r_pi;
                                    n_ai = r_pi;
                                end
                            end
                            ADDR_FLAGS: begin
                                o_rsp.rdata = {r_flags, 6'b0};
                                n_flags[0]  = 1'b0;
                            end
                            default: o_rsp.status = ST_BAD_READ;
                        endcase
                    end
                end
                OP_WRITE: begin
                    if (!i_ram_select) begin
                        if (i_addr[2]) begin
                            n_tv       = i_write_data;
                            n_pc       = len;
                            n_ai       = len;
                            n_pi       = len;
                            n_flags[1] = 1'b0;
                            step       = 1'b1;
                        end else begin
                            o_rsp.status = ST_BAD_WRITE;
                        end
                    end
                end
                default: ;
            endcase
        end

        // timer step: underflow drops to a one-tick interval
        if (step) begin
            if (n_tv == '0) begin
                n_flags = 2'b11;
                n_ai    = INTERVAL_W'(1);
                n_pc    = INTERVAL_W'(1);
            end else begin
                n_pc    = n_ai;
            end
            n_tv = n_tv - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv    <= '0;
            r_flags <= '0;
            r_pc    <= INTERVAL_W'(1024);
            r_ai    <= INTERVAL_W'(1024);
            r_pi    <= INTERVAL_W'(1024);
        end else begin
            r_tv    <= n_tv;
            r_flags <= n_flags;
            r_pc    <= n_pc;
            r_ai    <= n_ai;
            r_pi    <= n_pi;
        end
    end

endmodule

// ===== design/riot_ram_interval_timer_top.sv =====
// ----------------------------------------------------------------------------
// RIOT RAM and interval timer
// Bus-side model of a RAM, switch port and interval timer chip.
// ----------------------------------------------------------------------------
// Each request on the slave stream is a clock tick, a bus read or a bus write
// and yields exactly one response on the master stream, in order. A new
// request is taken every cycle while stage 1 is empty or drains; the response
// passes through stage 1, which waits on the registered read of the RAM, and
// then the output register. Timer, prescaler and flags update in the cycle of
// the accept, so back-to-back requests see each other's effects at once. RAM entries read
// before being written return undefined data. RAM_DEPTH must be a power of
// two; the RAM index is the low address bits.
// ----------------------------------------------------------------------------
`include "riot_ram_interval_timer_top_macros.svh"

module riot_ram_interval_timer_top
    import rit_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] addr, [15:8] write_data
    input  logic [2:0]  s_axis_tuser,   // [1:0] op, [2] ram_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] read_data
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic [1:0]       in_op;
    logic             in_ram_sel;
    logic [7:0]       in_addr;
    logic [7:0]       in_wdata;
    logic             accept;
    logic             ram_re;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    t_port_rsp        port_rsp;

    // stage 1: waits on RAM read data
    logic             r_s1_valid;
    logic             r_s1_ram_rd;
    t_port_rsp        r_s1_rsp;
    logic             s1_move;

    // output register
    logic             r_out_valid;
    t_port_rsp        r_out_rsp;

    assign in_op      = s_axis_tuser[1:0];
    assign in_ram_sel = s_axis_tuser[2];
    assign in_addr    = s_axis_tdata[7:0];
    assign in_wdata   = s_axis_tdata[15:8];

    // stage 1 drains into the output register when that is free or taken;
    // no request is taken while reset is held
    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_s1_valid || s1_move);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ram_re = accept && in_ram_sel && (in_op == OP_READ);
    assign ram_we = accept && in_ram_sel && (in_op == OP_WRITE);

    // RAM read data holds while stage 1 stalls, since reads only fire on accept
    rit_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_addr[RAM_AW-1:0]),
        .i_wdata (in_wdata),
        .i_re    (ram_re),
        .i_raddr (in_addr[RAM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    rit_timer u_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (in_op),
        .i_ram_select (in_ram_sel),
        .i_addr       (in_addr),
        .i_write_data (in_wdata),
        .o_rsp        (port_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rsp    <= port_rsp;
            r_s1_ram_rd <= ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_rsp.rdata  <= r_s1_ram_rd ? ram_rdata : r_s1_rsp.rdata;
            r_out_rsp.status <= r_s1_rsp.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rsp.rdata;
    assign m_axis_tuser  = r_out_rsp.status;

    // a full pipeline with a stalled output must refuse new requests
    `RIT_ASSERT(a_stall_blocks_input, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready,
        "request accepted while pipeline is full")
    // every accepted request occupies stage 1 in the next cycle
    `RIT_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, accept, r_s1_valid,
        "accepted request lost before stage 1")
    // status code three is never produced
    `RIT_ASSERT(a_status_legal, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tuser != 2'd3),
        "illegal status code on response")

endmodule
